@@ rtl/core/fbsm_pkg.sv @@
// shared types, constants and the byte-to-code mapping of the substring matcher
package fbsm_pkg;

  // configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam int PAT_REG_W = 60;
  localparam int SYMS_PER_REG = 12;
  localparam int SYM_W = 5;
  localparam int LEN_W = 5;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  // special symbol codes
  localparam logic [SYM_W-1:0] CODE_DIGIT_ZERO = 5'd26;
  localparam logic [SYM_W-1:0] CODE_DIGIT_NINE = 5'd27;
  localparam logic [SYM_W-1:0] CODE_PUNCT      = 5'd28;
  localparam logic [SYM_W-1:0] CODE_SPACE      = 5'd29;
  localparam logic [SYM_W-1:0] CODE_CTRL_ONE   = 5'd31;

  // digits '1'..'8' borrow the codes of z,q,j,x,k,b,y,w
  localparam logic [SYM_W-1:0] DIGIT_CODES [8] = '{
    5'd25, 5'd16, 5'd9, 5'd23, 5'd10, 5'd1, 5'd24, 5'd22
  };

  typedef struct packed {
    logic [PAT_REG_W-1:0] pat_low;
    logic [PAT_REG_W-1:0] pat_high;
    logic [LEN_W-1:0]     pat_len;
  } fbsm_cfg_t;

  typedef struct packed {
    logic             vld;
    logic [SYM_W-1:0] code;
  } fbsm_code_t;

  // map one text byte to its symbol code, vld low when the byte is skipped
  function automatic fbsm_code_t map_byte(input logic [7:0] b);
    fbsm_code_t res;
    logic [7:0] off;
    res.vld  = 1'b1;
    res.code = '0;
    off = 8'h00;
    case (b) inside
      [8'h61:8'h7A]: begin
        off = b - 8'h61;
        res.code = off[SYM_W-1:0];
      end
      [8'h41:8'h5A]: begin
        off = b - 8'h41;
        res.code = off[SYM_W-1:0];
      end
      8'h30: res.code = CODE_DIGIT_ZERO;
      8'h39: res.code = CODE_DIGIT_NINE;
      [8'h31:8'h38]: begin
        off = b - 8'h31;
        res.code = DIGIT_CODES[off[2:0]];
      end
      8'h20: res.code = CODE_SPACE;
      [8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]:
        res.code = CODE_PUNCT;
      8'h01: res.code = CODE_CTRL_ONE;
      default: res.vld = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/five_bit_substring_matcher_top.sv @@
// top level of the five-bit substring matcher
//
// Text bytes enter on the in_ stream: in_tdata carries the byte, in_tlast
// marks the final byte of a text. Each byte maps to a 5-bit symbol (or is
// skipped); the matcher keeps the most recent PATTERN_MAX symbols and raises
// a sticky flag whenever the newest pattern_len symbols equal the pattern.
// On the final byte of a text one transaction leaves on the out_ stream with
// bit 0 of out_tdata set if the pattern occurred; no other byte yields output.
// The pattern and its length are written through the cfg_ apb port between
// texts or while the input idles (registers at byte addresses 0, 8 and 16).
// A final byte passes through the input register, then the result register,
// before its result shows on out_tvalid.
// Throughput: one byte per cycle while results are taken; the mapping, window shift and parallel
// compare all fit between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_tready drops until the result is taken.
// Reset (synchronous, rst_n low) empties both registers, clears the window,
// count and flag, and sets the pattern to zero with length 1.
module five_bit_substring_matcher_top #(
  parameter int PATTERN_MAX = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] text_byte
  input  logic                        in_tlast,   // text_end
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [0] found, [7:1] zero
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fbsm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fbsm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fbsm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import fbsm_pkg::*;

  fbsm_cfg_t  cfg;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r;
  logic       out_free, proc, in_acc, found;

  fbsm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fbsm_core #(.PATTERN_MAX(PATTERN_MAX)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (proc),
    .text_byte (s1_byte_r),
    .text_end  (s1_end_r),
    .cfg       (cfg),
    .found     (found)
  );

  // pipeline flow control
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (proc ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (proc && s1_end_r) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_end_r) begin
      out_found_r <= found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r};

`ifndef SYNTHESIS
  // a held byte is never dropped without being processed
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !proc |=> s1_valid_r)
    else $error("input register lost a byte");

  // a pending result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(proc && s1_end_r))
    else $error("result register overwritten while stalled");

  // a new result only follows a processed final byte
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r && !out_tready) |-> $past(proc && s1_end_r))
    else $error("result appeared without a final byte");
`endif

endmodule

@@ rtl/core/fbsm_cfg.sv @@
// apb register file holding the pattern and its length
module fbsm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbsm_pkg::CFG_AW-1:0] paddr,
  input  logic [fbsm_pkg::CFG_DW-1:0] pwdata,
  output logic [fbsm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output fbsm_pkg::fbsm_cfg_t         cfg
);
  import fbsm_pkg::*;

  fbsm_cfg_t cfg_r;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_low  <= '0;
      cfg_r.pat_high <= '0;
      cfg_r.pat_len  <= LEN_W'(1);
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_PAT_LOW:  cfg_r.pat_low  <= pwdata[PAT_REG_W-1:0];
        REG_PAT_HIGH: cfg_r.pat_high <= pwdata[PAT_REG_W-1:0];
        REG_PAT_LEN:  cfg_r.pat_len  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[4:3])
      REG_PAT_LOW:  prdata = CFG_DW'(cfg_r.pat_low);
      REG_PAT_HIGH: prdata = CFG_DW'(cfg_r.pat_high);
      REG_PAT_LEN:  prdata = CFG_DW'(cfg_r.pat_len);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/fbsm_core.sv @@
// code window, code count, pattern compare and sticky match flag
module fbsm_core #(
  parameter int PATTERN_MAX = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          text_byte,
  input  logic                text_end,
  input  fbsm_pkg::fbsm_cfg_t cfg,
  output logic                found
);
  import fbsm_pkg::*;

  localparam int CW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LEN_W-1:0] PM_LEN = LEN_W'(PATTERN_MAX);
  localparam logic [CW-1:0]    PM_CNT = CW'(PATTERN_MAX);

  logic [SYM_W-1:0] win_r   [PATTERN_MAX];
  logic [SYM_W-1:0] win_nxt [PATTERN_MAX];
  logic [CW-1:0]    seen_r, seen_nxt;
  logic             match_r, match_nxt;
  logic [LEN_W-1:0] len_eff;
  logic [2*PAT_REG_W-1:0] pat_all;
  fbsm_code_t       cd;
  logic             syms_ok;

  assign cd      = map_byte(text_byte);
  assign len_eff = (cfg.pat_len > PM_LEN) ? PM_LEN : cfg.pat_len;
  assign pat_all = {cfg.pat_high, cfg.pat_low};

  // shift the new code in, newest at position 0
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_nxt[j] = win_r[j];
    end
    seen_nxt = seen_r;
    if (cd.vld) begin
      win_nxt[0] = cd.code;
      for (int j = 1; j < PATTERN_MAX; j++) begin
        win_nxt[j] = win_r[j-1];
      end
      if (seen_r < PM_CNT) seen_nxt = seen_r + CW'(1);
    end
  end

  // pattern symbol k must sit at window position len_eff-1-k
  always_comb begin
    logic [LEN_W-1:0] idx;
    syms_ok = 1'b1;
    idx = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      idx = len_eff - LEN_W'(k) - LEN_W'(1);
      if ((LEN_W'(k) < len_eff) &&
          (win_nxt[idx[IW-1:0]] != pat_all[SYM_W*k +: SYM_W])) begin
        syms_ok = 1'b0;
      end
    end
  end

  assign match_nxt = match_r | (syms_ok && (6'(seen_nxt) >= 6'(len_eff)));
  assign found     = match_nxt;

  // state update, cleared at the end of each text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      match_r <= 1'b0;
      for (int j = 0; j < PATTERN_MAX; j++) win_r[j] <= '0;
    end else if (step_en) begin
      if (text_end) begin
        seen_r  <= '0;
        match_r <= 1'b0;
        for (int j = 0; j < PATTERN_MAX; j++) win_r[j] <= '0;
      end else begin
        seen_r  <= seen_nxt;
        match_r <= match_nxt;
        for (int j = 0; j < PATTERN_MAX; j++) win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule
